@@ src/dsba_pkg.sv @@
// Package for the doorbell slot buddy allocator.
// Holds the transaction payload types and the action and status codes.
// No dependencies.
package dsba_pkg;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } dsba_action_e;

  typedef enum logic {
    ST_DONE = 1'b0,
    ST_FULL = 1'b1
  } dsba_status_e;

  typedef struct packed {
    logic       action;
    logic       size_order;
    logic [1:0] page_sel;
    logic [5:0] slot_sel;
  } dsba_in_t;

  typedef struct packed {
    logic       status;
    logic [1:0] page_out;
    logic [5:0] slot_out;
    logic       page_opened;
    logic       page_released;
  } dsba_out_t;

  typedef struct packed {
    logic hit;
    logic full;
  } dsba_flags_t;

endpackage

@@ src/dsba_map_unit.sv @@
// Shared bitmap unit: searches and updates the pair and single maps of one page.
// Serves both allocation and free transactions. Depends on dsba_pkg.
module dsba_map_unit import dsba_pkg::*; #(
  parameter int SLOTS_PER_PAGE = 64,
  localparam int PairCount = SLOTS_PER_PAGE / 2,
  localparam int SlotW = $clog2(SLOTS_PER_PAGE),
  localparam int PairW = (PairCount > 1) ? $clog2(PairCount) : 1
) (
  input  logic                      action_i,
  input  logic                      order_i,
  input  logic [SlotW-1:0]          slot_i,
  input  logic [PairCount-1:0]      pair_map_i,
  input  logic [SLOTS_PER_PAGE-1:0] single_map_i,
  output logic [PairCount-1:0]      pair_map_o,
  output logic [SLOTS_PER_PAGE-1:0] single_map_o,
  output logic [SlotW-1:0]          slot_o,
  output dsba_flags_t               flags_o
);

  logic             s_hit;
  logic [SlotW-1:0] s_idx;
  logic             p_hit;
  logic [PairW-1:0] p_idx;
  logic [SlotW-1:0] p_slot;
  logic [SlotW-1:0] buddy;
  logic             buddy_ok;
  logic [PairW-1:0] own_pair;
  logic             own_pair_ok;

  always_comb begin
    s_hit = 1'b0;
    s_idx = '0;
    for (int k = SLOTS_PER_PAGE - 1; k >= 0; k--) begin
      if (single_map_i[k]) begin
        s_hit = 1'b1;
        s_idx = SlotW'(k);
      end
    end
    p_hit = 1'b0;
    p_idx = '0;
    for (int k = PairCount - 1; k >= 0; k--) begin
      if (pair_map_i[k]) begin
        p_hit = 1'b1;
        p_idx = PairW'(k);
      end
    end
  end

  assign p_slot      = SlotW'({p_idx, 1'b0});
  assign buddy       = slot_i ^ SlotW'(1);
  assign buddy_ok    = (32'(slot_i | SlotW'(1)) < SLOTS_PER_PAGE);
  assign own_pair    = PairW'(slot_i >> 1);
  assign own_pair_ok = (32'(slot_i >> 1) < PairCount);

  always_comb begin
    pair_map_o   = pair_map_i;
    single_map_o = single_map_i;
    slot_o       = '0;
    flags_o.hit  = 1'b0;
    if (action_i == ACT_ALLOC) begin
      if (!order_i && s_hit) begin
        flags_o.hit         = 1'b1;
        single_map_o[s_idx] = 1'b0;
        slot_o              = s_idx;
      end else if (p_hit) begin
        flags_o.hit       = 1'b1;
        pair_map_o[p_idx] = 1'b0;
        slot_o            = p_slot;
        if (!order_i) begin
          single_map_o[p_slot | SlotW'(1)] = 1'b1;
        end
      end
    end else begin
      if (!order_i && buddy_ok && single_map_i[buddy]) begin
        single_map_o[buddy]  = 1'b0;
        pair_map_o[own_pair] = 1'b1;
      end else if (order_i) begin
        if (own_pair_ok) begin
          pair_map_o[own_pair] = 1'b1;
        end
      end else begin
        single_map_o[slot_i] = 1'b1;
      end
    end
    flags_o.full = &pair_map_o;
  end

endmodule

@@ src/doorbell_slot_buddy_allocator_unit.sv @@
// Doorbell slot buddy allocator: a small sequencer that drives one shared
// bitmap unit over a register file of per-page pair and single maps.
// Depends on dsba_pkg and dsba_map_unit.
//
// One transaction is taken at a time and the block is busy until its result
// is registered. The shared map unit handles one page at a time (map read
// in S_LOAD, then search and writeback in S_EXEC). An allocation scans the
// pages in order from page 0 and, if no live page has room, opens a new
// page or finds no room; a valid free loads and updates its own page, and an
// invalid free goes straight to its result. A finished result waits in the
// output register while the next transaction is taken.
module doorbell_slot_buddy_allocator_unit import dsba_pkg::*; #(
  parameter int PAGES          = 4,
  parameter int SLOTS_PER_PAGE = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dsba_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dsba_out_t out_data_o
);

  localparam int PairCount = SLOTS_PER_PAGE / 2;
  localparam int SlotW = $clog2(SLOTS_PER_PAGE);
  localparam int PageW = (PAGES > 1) ? $clog2(PAGES) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_EXEC = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  logic [PairCount-1:0]      pair_q [PAGES];
  logic [SLOTS_PER_PAGE-1:0] single_q [PAGES];
  logic [PAGES-1:0]          active_q, active_d;
  dsba_in_t                  req_q, req_d;
  logic [PageW-1:0]          page_q, page_d;
  logic [PairCount-1:0]      wrk_pair_q, wrk_pair_d;
  logic [SLOTS_PER_PAGE-1:0] wrk_single_q, wrk_single_d;
  logic                      opened_q, opened_d;
  logic                      inact_found_q, inact_found_d;
  logic [PageW-1:0]          inact_page_q, inact_page_d;
  dsba_out_t                 res_q, res_d;
  dsba_out_t                 out_q, out_d;
  logic                      out_valid_q, out_valid_d;
  logic                      map_we;

  logic [PairCount-1:0]      unit_pair;
  logic [SLOTS_PER_PAGE-1:0] unit_single;
  logic [SlotW-1:0]          unit_slot;
  dsba_flags_t               unit_flags;

  logic in_fire;
  logic free_valid;
  logic out_free;
  logic page_live;
  logic found_now;

  dsba_map_unit #(
    .SLOTS_PER_PAGE(SLOTS_PER_PAGE)
  ) u_map (
    .action_i    (req_q.action),
    .order_i     (req_q.size_order),
    .slot_i      (SlotW'(req_q.slot_sel)),
    .pair_map_i  (wrk_pair_q),
    .single_map_i(wrk_single_q),
    .pair_map_o  (unit_pair),
    .single_map_o(unit_single),
    .slot_o      (unit_slot),
    .flags_o     (unit_flags)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign free_valid = (32'(in_data_i.page_sel) < PAGES) &&
                      (32'(in_data_i.slot_sel) < SLOTS_PER_PAGE) &&
                      active_q[PageW'(in_data_i.page_sel)];
  assign out_free   = !out_valid_q || out_ready_i;
  assign page_live  = active_q[page_q] || opened_q;
  assign found_now  = inact_found_q || !active_q[page_q];

  always_comb begin
    state_d       = state_q;
    active_d      = active_q;
    req_d         = req_q;
    page_d        = page_q;
    wrk_pair_d    = wrk_pair_q;
    wrk_single_d  = wrk_single_q;
    opened_d      = opened_q;
    inact_found_d = inact_found_q;
    inact_page_d  = inact_page_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    map_we        = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_d         = in_data_i;
          opened_d      = 1'b0;
          inact_found_d = 1'b0;
          res_d         = '0;
          if (in_data_i.action == ACT_ALLOC) begin
            page_d  = '0;
            state_d = S_LOAD;
          end else if (free_valid) begin
            page_d  = PageW'(in_data_i.page_sel);
            state_d = S_LOAD;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_LOAD: begin
        wrk_pair_d   = pair_q[page_q];
        wrk_single_d = single_q[page_q];
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        if (req_q.action == ACT_FREE) begin
          map_we              = 1'b1;
          res_d.page_released = unit_flags.full;
          if (unit_flags.full) begin
            active_d[page_q] = 1'b0;
          end
          state_d = S_FIN;
        end else if (page_live && unit_flags.hit) begin
          map_we            = 1'b1;
          active_d[page_q]  = 1'b1;
          res_d.status      = ST_DONE;
          res_d.page_out    = 2'(page_q);
          res_d.slot_out    = 6'(unit_slot);
          res_d.page_opened = opened_q;
          state_d           = S_FIN;
        end else begin
          if (!inact_found_q && !active_q[page_q]) begin
            inact_found_d = 1'b1;
            inact_page_d  = page_q;
          end
          if (32'(page_q) == PAGES - 1) begin
            if (found_now) begin
              page_d       = inact_found_q ? inact_page_q : page_q;
              wrk_pair_d   = '1;
              wrk_single_d = '0;
              opened_d     = 1'b1;
            end else begin
              res_d.status = ST_FULL;
              state_d      = S_FIN;
            end
          end else begin
            page_d  = page_q + PageW'(1);
            state_d = S_LOAD;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q         <= req_d;
    page_q        <= page_d;
    wrk_pair_q    <= wrk_pair_d;
    wrk_single_q  <= wrk_single_d;
    opened_q      <= opened_d;
    inact_found_q <= inact_found_d;
    inact_page_q  <= inact_page_d;
    res_q         <= res_d;
    out_q         <= out_d;
    if (map_we) begin
      pair_q[page_q]   <= unit_pair;
      single_q[page_q] <= unit_single;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/dsba_checker.sv @@
// Port-level checker for the doorbell slot buddy allocator.
// Depends on dsba_pkg; bound to doorbell_slot_buddy_allocator_unit below.
module dsba_checker import dsba_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input dsba_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input dsba_out_t out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("Input transaction changed or dropped while waiting.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result changed or dropped while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input ready right after an accepted transaction.");

  a_full_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |->
      out_data_o.page_out == 2'd0 && out_data_o.slot_out == 6'd0 &&
      !out_data_o.page_opened && !out_data_o.page_released)
    else $error("Full status carries nonzero fields.");

  a_release_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.page_released |->
      out_data_o.status == ST_DONE && !out_data_o.page_opened &&
      out_data_o.page_out == 2'd0 && out_data_o.slot_out == 6'd0)
    else $error("Page release reported together with allocation fields.");

endmodule

bind doorbell_slot_buddy_allocator_unit dsba_checker u_dsba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
